FILE: hdl/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

  // Frames per message before the limit error fires (1..7).
  localparam int MAX_FRAMES = 3;

  // Depth of the queue between the parser and the output register.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMASKED  = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_FRAMES    = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } byte_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] payload_byte;
    logic [3:0] message_opcode;
    logic       end_of_message;
    logic [1:0] error_code;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/wsd_parser.sv
`default_nettype none

module wsd_parser (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 take,
  input  wsd_pkg::byte_item_t item,
  output logic                push,
  output wsd_pkg::result_t    push_item,
  output logic                at_frame_start
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;

  logic [2:0]  phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  kind, kind_next;
  logic [3:0]  msg_op, msg_op_next;
  logic        masked, masked_next;
  logic [2:0]  lbc, lbc_next;
  logic [63:0] rem, rem_next;
  logic [31:0] key, key_next;
  logic [1:0]  idx, idx_next;
  logic [2:0]  frames, frames_next;

  logic        done;
  logic        have_data;
  logic [7:0]  data;
  logic [7:0]  key_byte;
  logic        err_unmasked;
  logic        kind_is_data;
  logic [2:0]  frames_inc;
  logic [63:0] rem_dec;
  logic [7:0]  b;

  assign b            = item.rx_byte;
  // data opcodes are continuation, text and binary only
  assign kind_is_data = (kind <= 4'd2);
  assign frames_inc   = frames + 3'd1;
  assign rem_dec      = rem - 64'd1;
  assign at_frame_start = (phase == PH_HDR0);

  always_comb begin
    case (idx)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  always_comb begin
    phase_next   = phase;
    fin_next     = fin;
    kind_next    = kind;
    msg_op_next  = msg_op;
    masked_next  = masked;
    lbc_next     = lbc;
    rem_next     = rem;
    key_next     = key;
    idx_next     = idx;
    frames_next  = frames;
    done         = 1'b0;
    have_data    = 1'b0;
    data         = 8'd0;
    err_unmasked = 1'b0;
    push         = 1'b0;
    push_item    = '0;

    case (phase)
      PH_HDR1: begin
        masked_next = b[7];
        if (kind_is_data && !b[7]) begin
          err_unmasked = 1'b1;
        end
        if (kind_is_data && msg_op == 4'd0 && kind != 4'd0) begin
          msg_op_next = kind;
        end
        key_next = '0;
        idx_next = '0;
        rem_next = '0;
        if (b[6:0] == 7'd126) begin
          lbc_next   = 3'd1;
          phase_next = PH_EXT;
        end else if (b[6:0] == 7'd127) begin
          lbc_next   = 3'd7;
          phase_next = PH_EXT;
        end else begin
          rem_next = {57'd0, b[6:0]};
          if (b[7]) begin
            phase_next = PH_KEY;
          end else if (b[6:0] != 7'd0) begin
            phase_next = PH_BODY;
          end else begin
            done = 1'b1;
          end
        end
      end
      PH_EXT: begin
        rem_next = {rem[55:0], b};
        if (lbc == 3'd0) begin
          if (masked) begin
            phase_next = PH_KEY;
          end else if (rem_next != 64'd0) begin
            phase_next = PH_BODY;
          end else begin
            done = 1'b1;
          end
        end else begin
          lbc_next = lbc - 3'd1;
        end
      end
      PH_KEY: begin
        key_next = {key[23:0], b};
        if (idx == 2'd3) begin
          idx_next = 2'd0;
          if (rem == 64'd0) begin
            done = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      PH_BODY: begin
        if (kind_is_data) begin
          have_data = 1'b1;
          data      = b ^ (masked ? key_byte : 8'd0);
        end
        idx_next = idx + 2'd1;
        rem_next = rem_dec;
        if (rem_dec == 64'd0) begin
          done = 1'b1;
        end
      end
      default: begin
        fin_next   = b[7];
        kind_next  = b[3:0];
        phase_next = PH_HDR1;
      end
    endcase

    if (done) begin
      phase_next = PH_HDR0;
    end

    if (err_unmasked) begin
      push                 = 1'b1;
      push_item.error_code = wsd_pkg::ERR_UNMASKED;
    end else if (done && kind_is_data && fin) begin
      push                     = 1'b1;
      push_item.data_valid     = have_data;
      push_item.payload_byte   = data;
      push_item.message_opcode = msg_op_next;
      push_item.end_of_message = 1'b1;
      msg_op_next              = 4'd0;
      frames_next              = 3'd0;
    end else if (done && frames_inc >= 3'(wsd_pkg::MAX_FRAMES)) begin
      push                 = 1'b1;
      push_item.error_code = wsd_pkg::ERR_FRAMES;
    end else if (item.buffer_end) begin
      push                 = 1'b1;
      push_item.error_code = wsd_pkg::ERR_TRUNCATED;
    end else begin
      if (done) begin
        frames_next = frames_inc;
      end
      if (have_data) begin
        push                     = 1'b1;
        push_item.data_valid     = 1'b1;
        push_item.payload_byte   = data;
        push_item.message_opcode = msg_op_next;
      end
    end

    // any error returns the parser to its reset state
    if (push && push_item.error_code != wsd_pkg::ERR_NONE) begin
      phase_next  = PH_HDR0;
      fin_next    = 1'b0;
      kind_next   = 4'd0;
      msg_op_next = 4'd0;
      masked_next = 1'b0;
      lbc_next    = 3'd0;
      rem_next    = '0;
      key_next    = '0;
      idx_next    = 2'd0;
      frames_next = 3'd0;
    end

    push = push && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR0;
      fin    <= 1'b0;
      kind   <= 4'd0;
      msg_op <= 4'd0;
      masked <= 1'b0;
      lbc    <= 3'd0;
      rem    <= '0;
      key    <= '0;
      idx    <= 2'd0;
      frames <= 3'd0;
    end else if (take) begin
      phase  <= phase_next;
      fin    <= fin_next;
      kind   <= kind_next;
      msg_op <= msg_op_next;
      masked <= masked_next;
      lbc    <= lbc_next;
      rem    <= rem_next;
      key    <= key_next;
      idx    <= idx_next;
      frames <= frames_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wsd_emit.sv
`default_nettype none

module wsd_emit (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wsd_pkg::result_t push_item,
  output logic             full,
  output logic             empty,
  output logic             result_valid,
  input  wire              result_stall,
  output wsd_pkg::result_t result_item
);

  localparam int AW = wsd_pkg::QUEUE_AW;

  wsd_pkg::result_t mem [wsd_pkg::QUEUE_DEPTH];

  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          load;

  assign full  = (count == (AW+1)'(wsd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  // output register takes the head whenever it is free or being drained
  assign load  = !empty && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
    if (load) begin
      result_item <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(load);
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/websocket_frame_deframer_top.sv
// WebSocket (RFC 6455) receive deframer. Bytes of the stream enter on the
// byte channel one per transaction, at up to one per clock. The parser
// tracks the frame header (FIN/opcode, mask bit and 7-bit length, 16- or
// 64-bit big-endian extended length, 4-byte masking key), unmasks payload
// bytes of data frames and skips control and unknown frames whole. Each
// payload byte gives one result carrying the message opcode; the byte that
// finishes a FIN data frame carries end_of_message (with data_valid low for
// an empty final frame). An unmasked data frame, buffer_end on a byte that
// does not finish a message, or more than MAX_FRAMES frames in a message
// yield one error result and return the parser to its reset state.
// Throughput is one byte per clock while byte_stall is low: the parser
// steps once per byte. Results go through a 4-entry queue into an output
// register. byte_stall rises only while that queue is full, i.e. after
// the result side has held off for a while.

`default_nettype none

module websocket_frame_deframer_top (
  input  wire                 clk,
  input  wire                 rst,
  // byte channel
  input  wire                 byte_valid,
  output logic                byte_stall,
  input  wsd_pkg::byte_item_t byte_item,
  // result channel
  output logic                result_valid,
  input  wire                 result_stall,
  output wsd_pkg::result_t    result_item
);

  logic             take;
  logic             push;
  wsd_pkg::result_t push_item;
  logic             q_full;
  logic             q_empty;
  logic             at_frame_start;

  // stall only on a full queue; every accepted byte may produce a result
  assign byte_stall = q_full;
  assign take       = byte_valid && !q_full;

  // front: header parsing, unmasking and error checks
  wsd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .item           (byte_item),
    .push           (push),
    .push_item      (push_item),
    .at_frame_start (at_frame_start)
  );

  // back: result queue and output register
  wsd_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_item    (push_item),
    .full         (q_full),
    .empty        (q_empty),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  // an error or end of message always leaves the parser at a frame header
  a_restart : assert property (@(posedge clk) disable iff (rst)
    push && (push_item.error_code != wsd_pkg::ERR_NONE || push_item.end_of_message)
      |=> at_frame_start)
    else $error("parser not at frame start after error or end of message");

  // error results carry nothing else
  a_err_clean : assert property (@(posedge clk) disable iff (rst)
    push && push_item.error_code != wsd_pkg::ERR_NONE
      |-> !push_item.data_valid && !push_item.end_of_message
          && push_item.message_opcode == 4'd0)
    else $error("error result carries payload fields");

  // a queued result reaches an empty output register in the next cycle
  a_drain : assert property (@(posedge clk) disable iff (rst)
    !q_empty && !result_valid |=> result_valid)
    else $error("queued result not moved to output register");

  // no push into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push into full result queue");

endmodule

`default_nettype wire
